/* design/ripd_pkg.sv */
// Package for the remote input packet deframer: packet type codes, event kind
// codes and the result beat structure. No dependencies.
`default_nettype none

package ripd_pkg;

    // Type bytes that open a packet.
    localparam logic [7:0] TYPE_ORIENT   = 8'h01;
    localparam logic [7:0] TYPE_CLICK    = 8'h02;
    localparam logic [7:0] TYPE_SCROLL   = 8'h03;
    localparam logic [7:0] TYPE_SENS     = 8'h04;
    localparam logic [7:0] TYPE_DBLCLICK = 8'h05;
    localparam logic [7:0] TYPE_SHORTCUT = 8'h06;
    localparam logic [7:0] TYPE_VOLUME   = 8'h07;
    localparam logic [7:0] TYPE_TEXT     = 8'h08;
    localparam logic [7:0] TYPE_RECENTER = 8'h09;
    localparam logic [7:0] TYPE_PING     = 8'hFF;

    // Event kinds reported on the result channel.
    localparam logic [3:0] EV_ORIENT   = 4'd0;
    localparam logic [3:0] EV_CLICK    = 4'd1;
    localparam logic [3:0] EV_SCROLL   = 4'd2;
    localparam logic [3:0] EV_SENS     = 4'd3;
    localparam logic [3:0] EV_DBLCLICK = 4'd4;
    localparam logic [3:0] EV_SHORTCUT = 4'd5;
    localparam logic [3:0] EV_VOLUME   = 4'd6;
    localparam logic [3:0] EV_TEXT     = 4'd7;
    localparam logic [3:0] EV_RECENTER = 4'd8;

    // Click button codes.
    localparam logic [2:0] BTN_LEFT   = 3'd0;
    localparam logic [2:0] BTN_RIGHT  = 3'd1;
    localparam logic [2:0] BTN_MIDDLE = 3'd2;

    localparam int unsigned ORIENT_BYTES = 16;
    localparam int unsigned POS_W        = 17;

    typedef struct packed {
        logic              text_last;
        logic              text_char_valid;
        logic [7:0]        text_char;
        logic signed [15:0] scroll_delta;
        logic              flag_bit;
        logic [2:0]        small_code;
        logic [31:0]       word_fourth;
        logic [31:0]       word_third;
        logic [31:0]       word_second;
        logic [31:0]       word_first;
        logic [3:0]        event_kind;
    } result_t;

endpackage

`default_nettype wire

/* design/ripd_decoder.sv */
// Packet decoder for the remote input packet deframer: frame state, payload
// assembly and one result per completed event. Depends on ripd_pkg.
`default_nettype none

module ripd_decoder import ripd_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_push,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_disc,
    output logic               res_push,
    output result_t            res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ORIENT,
        ST_CLICK,
        ST_SCROLL,
        ST_SENS,
        ST_SHORTCUT,
        ST_VOLUME,
        ST_TEXT
    } frame_t;

    frame_t             frame_reg, frame_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [31:0]        words_reg [4];
    logic [31:0]        words_next [4];
    logic [15:0]        len_reg, len_next;
    logic [7:0]         header_reg, header_next;
    logic               has_res;

    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   pos_dec;
    logic [1:0]         lane_word;
    logic [1:0]         lane_byte;
    logic [15:0]        len_full;

    assign pos_inc  = pos_reg + POS_W'(1);
    assign pos_dec  = pos_reg - POS_W'(1);
    assign len_full = {in_byte, len_reg[7:0]};

    always_comb begin
        frame_next  = frame_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        header_next = header_reg;
        for (int i = 0; i < 4; i++) begin
            words_next[i] = words_reg[i];
        end
        has_res     = 1'b0;
        res         = '0;
        lane_word   = (frame_reg == ST_SENS) ? 2'd0 : pos_reg[3:2];
        lane_byte   = pos_reg[1:0];

        if (in_disc) begin
            frame_next = ST_IDLE;
            pos_next   = '0;
        end else begin
            case (frame_reg)
                ST_IDLE: begin
                    pos_next = '0;
                    case (in_byte)
                        TYPE_ORIENT:   frame_next = ST_ORIENT;
                        TYPE_CLICK:    frame_next = ST_CLICK;
                        TYPE_SCROLL:   frame_next = ST_SCROLL;
                        TYPE_SENS:     frame_next = ST_SENS;
                        TYPE_SHORTCUT: frame_next = ST_SHORTCUT;
                        TYPE_VOLUME:   frame_next = ST_VOLUME;
                        TYPE_TEXT:     frame_next = ST_TEXT;
                        TYPE_DBLCLICK: begin
                            has_res        = 1'b1;
                            res.event_kind = EV_DBLCLICK;
                        end
                        TYPE_RECENTER: begin
                            has_res        = 1'b1;
                            res.event_kind = EV_RECENTER;
                        end
                        default: ; // Ping and unknown types are dropped.
                    endcase
                end
                ST_ORIENT, ST_SENS: begin
                    words_next[lane_word][lane_byte*8 +: 8] = in_byte;
                    if ((frame_reg == ST_ORIENT && pos_inc < POS_W'(ORIENT_BYTES))
                        || (frame_reg == ST_SENS && pos_reg < POS_W'(3))) begin
                        pos_next = pos_inc;
                    end else begin
                        has_res         = 1'b1;
                        res.event_kind  = (frame_reg == ST_ORIENT) ? EV_ORIENT : EV_SENS;
                        res.word_first  = words_next[0];
                        if (frame_reg == ST_ORIENT) begin
                            res.word_second = words_next[1];
                            res.word_third  = words_next[2];
                            res.word_fourth = words_next[3];
                        end
                        frame_next = ST_IDLE;
                        pos_next   = '0;
                    end
                end
                ST_CLICK, ST_SCROLL: begin
                    if (pos_reg == '0) begin
                        header_next = in_byte;
                        pos_next    = POS_W'(1);
                    end else begin
                        has_res = 1'b1;
                        if (frame_reg == ST_CLICK) begin
                            res.event_kind = EV_CLICK;
                            res.small_code = (header_reg == 8'd1) ? BTN_LEFT :
                                             (header_reg == 8'd2) ? BTN_RIGHT : BTN_MIDDLE;
                            res.flag_bit   = (in_byte == 8'd1);
                        end else begin
                            res.event_kind   = EV_SCROLL;
                            res.scroll_delta = {in_byte, header_reg};
                        end
                        frame_next = ST_IDLE;
                        pos_next   = '0;
                    end
                end
                ST_SHORTCUT: begin
                    frame_next = ST_IDLE;
                    pos_next   = '0;
                    if (in_byte >= 8'd1 && in_byte <= 8'd5) begin
                        has_res        = 1'b1;
                        res.event_kind = EV_SHORTCUT;
                        res.small_code = 3'(in_byte - 8'd1);
                    end
                end
                ST_VOLUME: begin
                    frame_next     = ST_IDLE;
                    pos_next       = '0;
                    has_res        = 1'b1;
                    res.event_kind = EV_VOLUME;
                    // Signed direction byte: strictly positive means up.
                    res.flag_bit   = !in_byte[7] && (in_byte != 8'd0);
                end
                ST_TEXT: begin
                    if (pos_reg == '0) begin
                        len_next = {8'd0, in_byte};
                        pos_next = POS_W'(1);
                    end else if (pos_reg == POS_W'(1)) begin
                        len_next = len_full;
                        if (len_full == 16'd0) begin
                            has_res        = 1'b1;
                            res.event_kind = EV_TEXT;
                            res.text_last  = 1'b1;
                            frame_next     = ST_IDLE;
                            pos_next       = '0;
                        end else begin
                            pos_next = POS_W'(2);
                        end
                    end else begin
                        has_res             = 1'b1;
                        res.event_kind      = EV_TEXT;
                        res.text_char       = in_byte;
                        res.text_char_valid = 1'b1;
                        if (pos_dec >= {1'b0, len_reg}) begin
                            res.text_last = 1'b1;
                            frame_next    = ST_IDLE;
                            pos_next      = '0;
                        end else begin
                            pos_next = pos_inc;
                        end
                    end
                end
                default: begin
                    frame_next = ST_IDLE;
                    pos_next   = '0;
                end
            endcase
        end
    end

    assign res_push = in_push && has_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= ST_IDLE;
            pos_reg   <= '0;
        end else if (in_push) begin
            frame_reg <= frame_next;
            pos_reg   <= pos_next;
        end
        if (in_push) begin
            len_reg    <= len_next;
            header_reg <= header_next;
            for (int i = 0; i < 4; i++) begin
                words_reg[i] <= words_next[i];
            end
        end
    end

endmodule

`default_nettype wire

/* design/ripd_out_buffer.sv */
// Two-entry output register with skid stage for the deframer result channel.
// Keeps the upstream ready registered. Depends on ripd_pkg.
`default_nettype none

module ripd_out_buffer import ripd_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    up_push,
    input  wire result_t up_data,
    output logic         up_ready,
    output logic         dn_valid,
    input  wire logic    dn_ready,
    output result_t      dn_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;

    assign up_ready = !skid_valid_reg;
    assign dn_valid = main_valid_reg;
    assign dn_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (dn_ready || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= up_push;
            end
        end else if (up_push) begin
            skid_valid_reg <= 1'b1;
        end

        if (dn_ready || !main_valid_reg) begin
            main_reg <= skid_valid_reg ? skid_reg : up_data;
        end else if (up_push) begin
            skid_reg <= up_data;
        end
    end

endmodule

`default_nettype wire

/* design/remote_input_packet_deframer.sv */
// Top level of the remote input packet deframer: stream ports, packet decoder
// and output buffer. Depends on ripd_pkg, ripd_decoder and ripd_out_buffer.
`default_nettype none

// The deframer takes one received link byte per beat and decodes typed
// packets (orientation, click, scroll, sensitivity, double click, shortcut,
// volume, dictation text and recenter) into event beats. It accepts one input
// beat every clock cycle while tready is high. An event appears on the result
// channel in the cycle after the input beat that completes it when no earlier
// event is waiting there. The rate is set by the combinational decode
// step between the frame state registers and the two-entry output
// buffer. Multi-byte fields are little-endian. Ping and unknown type bytes are
// consumed silently, as are shortcut packets with an id outside one to five.
// A text packet yields one event per text byte with tlast on the final one,
// or a single empty event with tlast when its length is zero. An input beat
// with tuser set marks a link drop: its byte is ignored and any partial
// packet is discarded. Fields that an event kind does not use read as zero.
// s_axis_tready stays high while the output buffer has a free skid entry, so
// after the result side stalls the input keeps flowing until a second event
// is waiting; tready drops in the cycle after that event is taken.

module remote_input_packet_deframer import ripd_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [7:0] rx_byte
    input  wire logic [7:0]   s_axis_tdata,
    // [0] disconnect
    input  wire logic         s_axis_tuser,

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] word_first, [63:32] word_second, [95:64] word_third,
    // [127:96] word_fourth, [130:128] small_code, [131] flag_bit,
    // [147:132] scroll_delta, [155:148] text_char, [156] text_char_valid,
    // [159:157] zero
    output logic [159:0]      m_axis_tdata,
    // [3:0] event_kind
    output logic [3:0]        m_axis_tuser,
    // text_last
    output logic              m_axis_tlast
);

    logic    in_push;
    logic    res_push;
    result_t res;
    result_t out_data;

    // A beat is taken whenever the output buffer can hold its possible event.
    assign in_push = s_axis_tvalid && s_axis_tready;

    ripd_decoder u_decoder (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_push  (in_push),
        .in_byte  (s_axis_tdata),
        .in_disc  (s_axis_tuser),
        .res_push (res_push),
        .res      (res)
    );

    ripd_out_buffer u_out_buffer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_push  (res_push),
        .up_data  (res),
        .up_ready (s_axis_tready),
        .dn_valid (m_axis_tvalid),
        .dn_ready (m_axis_tready),
        .dn_data  (out_data)
    );

    // Pack the result fields onto the stream, first field in the lowest bits.
    assign m_axis_tdata = {3'b000,
                           out_data.text_char_valid,
                           out_data.text_char,
                           out_data.scroll_delta,
                           out_data.flag_bit,
                           out_data.small_code,
                           out_data.word_fourth,
                           out_data.word_third,
                           out_data.word_second,
                           out_data.word_first};
    assign m_axis_tuser = out_data.event_kind;
    assign m_axis_tlast = out_data.text_last;

endmodule

`default_nettype wire
